// ===== rtl/core/orbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Overwriting ring byte buffer package
// Shared types, operation codes and constants of the ring buffer block.
// ----------------------------------------------------------------------------
package orbb_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int CAP_RESET = 256;

  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_READ   = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] index;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ok;
    logic [8:0] fill_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } ctl_stat_t;

endpackage

// ===== rtl/core/orbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ring buffer controller
// Sequences the clearing pass after reset and the accept, execute and result
// beats of each operation.
// ----------------------------------------------------------------------------
module orbb_ctrl
  import orbb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output ctl_cmd_t  cmd,
  input  ctl_stat_t stat
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        busy      = 1'b0;
        out_valid = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/orbb_dpath.sv =====
// ----------------------------------------------------------------------------
// Ring buffer datapath
// Holds the slot memory, the ring pointers, the fill count and the capacity,
// and forms the result of each operation.
// ----------------------------------------------------------------------------
module orbb_dpath
  import orbb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_cmd_t   cmd,
  output ctl_stat_t  stat,
  input  in_item_t   in_item,
  output out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CAP_W    = $clog2(DEPTH + 1);
  localparam int WW       = ((CAP_W > 8) ? CAP_W : 9) + 1;
  localparam int CAP_INIT = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q_r;
  logic [AW-1:0]    sweep_r;
  in_item_t         item_r;
  logic             ok_r;
  logic             rd_sel_r;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [AW-1:0]    oldest_r, oldest_nxt;
  logic [AW-1:0]    newest_r, newest_nxt;
  logic [CAP_W-1:0] count_r, count_nxt;
  logic             ok_nxt;
  logic             rd_sel_nxt;

  logic [WW-1:0] cap_w, old_w, new_w, cnt_w, idx_w;
  logic [WW-1:0] lim_w, sum_w, phys_w, new_inc_w;
  logic [WW-1:0] loc_new_w, back_w, loc_old_w;
  logic          in_range;
  logic          is_append;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] phys_a;

  assign cap_w    = WW'(cap_r);
  assign old_w    = WW'(oldest_r);
  assign new_w    = WW'(newest_r);
  assign cnt_w    = WW'(count_r);
  assign idx_w    = WW'(item_r.index);
  assign in_range = idx_w < cap_w;
  assign is_append = item_r.kind == KIND_APPEND;

  always_comb begin
    lim_w = WW'(cfg_wr_data);
    if (lim_w == '0) begin
      lim_w = WW'(1);
    end else if (lim_w > WW'(DEPTH)) begin
      lim_w = WW'(DEPTH);
    end
  end

  assign sum_w     = old_w + idx_w;
  assign phys_w    = (sum_w >= cap_w) ? (sum_w - cap_w) : sum_w;
  assign phys_a    = phys_w[AW-1:0];
  assign new_inc_w = ((new_w + WW'(1)) < cap_w) ? (new_w + WW'(1)) : '0;

  // The oldest slot lies one less than the held count behind the newest slot.
  assign loc_new_w = is_append ? new_inc_w : new_w;
  assign back_w    = is_append ? (cap_w - WW'(1)) : (cnt_w - WW'(2));
  assign loc_old_w = (loc_new_w >= back_w) ? (loc_new_w - back_w)
                                           : (cap_w + loc_new_w - back_w);

  always_comb begin
    cap_nxt    = cap_r;
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    count_nxt  = count_r;
    ok_nxt     = ok_r;
    rd_sel_nxt = rd_sel_r;
    if (cfg_wr_en) begin
      cap_nxt    = CAP_W'(lim_w);
      oldest_nxt = '0;
      newest_nxt = AW'(lim_w - WW'(1));
      count_nxt  = '0;
    end else if (cmd.exec) begin
      ok_nxt     = 1'b0;
      rd_sel_nxt = 1'b0;
      case (item_r.kind)
        KIND_APPEND: begin
          newest_nxt = AW'(new_inc_w);
          if (cnt_w < cap_w) begin
            count_nxt = count_r + CAP_W'(1);
            ok_nxt    = 1'b1;
          end else begin
            oldest_nxt = AW'(loc_old_w);
          end
        end
        KIND_READ: begin
          ok_nxt     = in_range;
          rd_sel_nxt = in_range;
        end
        KIND_WRITE: begin
          ok_nxt = in_range;
        end
        KIND_REMOVE: begin
          if (count_r != '0) begin
            ok_nxt    = 1'b1;
            count_nxt = count_r - CAP_W'(1);
            if (count_r == CAP_W'(1)) begin
              oldest_nxt = '0;
              newest_nxt = AW'(cap_w - WW'(1));
            end else begin
              oldest_nxt = AW'(loc_old_w);
            end
          end
        end
        KIND_CLEAR: begin
          ok_nxt     = 1'b1;
          oldest_nxt = '0;
          newest_nxt = AW'(cap_w - WW'(1));
          count_nxt  = '0;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_W'(CAP_INIT);
      oldest_r <= '0;
      newest_r <= AW'(CAP_INIT - 1);
      count_r  <= '0;
      sweep_r  <= '0;
      ok_r     <= 1'b0;
      rd_sel_r <= 1'b0;
    end else begin
      cap_r    <= cap_nxt;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      count_r  <= count_nxt;
      ok_r     <= ok_nxt;
      rd_sel_r <= rd_sel_nxt;
      if (cmd.sweep) begin
        sweep_r <= sweep_r + AW'(1);
      end
    end
  end

  assign stat.sweep_last = sweep_r == AW'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  assign mem_we = cmd.sweep
               || (cmd.exec && (is_append || (item_r.kind == KIND_WRITE && in_range)));

  always_comb begin
    if (cmd.sweep) begin
      mem_waddr = sweep_r;
    end else if (is_append) begin
      mem_waddr = AW'(new_inc_w);
    end else begin
      mem_waddr = phys_a;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd.sweep ? 8'd0 : item_r.value;
    end
    if (cmd.exec) begin
      mem_q_r <= mem[phys_a];
    end
  end

  assign out_item.read_data  = rd_sel_r ? mem_q_r : 8'd0;
  assign out_item.ok         = ok_r;
  assign out_item.fill_count = 9'(WW'(count_r));

endmodule

// ===== rtl/core/overwriting_ring_byte_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// Overwriting ring byte buffer
// A ring of byte slots that keeps the newest entries, with indexed access
// counted from the oldest entry.
// ----------------------------------------------------------------------------
// An operation is offered on in_item and taken at a clock edge where start is
// high and busy is low. Its single result beat appears on out_item with
// out_valid high for exactly one cycle; the receiver cannot stall it.
// After acceptance the slot memory access and pointer update take place in the
// execute state, and the result is registered for the result beat.
// A new operation may be started in the cycle that shows the previous result,
// but not while the previous operation is executing, when busy is high.
// The capacity register is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Each write empties the ring but keeps the slot contents.
// After reset the block runs a clearing pass that zeroes the slot memory,
// holding busy high; capacity writes are taken during it.
// Reset also empties the ring and sets the capacity to 256, or DEPTH if less.
// ----------------------------------------------------------------------------
module overwriting_ring_byte_buffer_unit
  import orbb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  orbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  orbb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_item     (in_item),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

// ===== verif/orbb_checker.sv =====
// ----------------------------------------------------------------------------
// Ring buffer result checker
// Watches the operation, result and capacity ports of the overwriting ring
// byte buffer. It keeps its own copy of the ring, predicts the result beat of
// every accepted operation and compares each result beat with the oldest
// prediction. It reports the failure count and the number of open
// predictions.
// ----------------------------------------------------------------------------
module orbb_checker
  import orbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  output int         failures,
  output int         waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] slots [256];
  logic [8:0] cap;
  logic [7:0] oldest;
  logic [7:0] newest;
  logic [8:0] count;
  out_item_t  pending_results [$];
  int         bad = 0;

  function automatic logic [8:0] clamp_capacity(logic [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (v > 9'd256) return 9'd256;
    return v;
  endfunction

  function void empty_ring();
    oldest = 8'd0;
    newest = 8'(cap - 9'd1);
    count  = 9'd0;
  endfunction

  function void find_oldest();
    logic [8:0] back;
    if (count != 9'd0) begin
      back = count - 9'd1;
      if ({1'b0, newest} >= back) oldest = 8'({1'b0, newest} - back);
      else oldest = 8'(cap + {1'b0, newest} - back);
    end else begin
      empty_ring();
    end
  endfunction

  function logic [7:0] slot_of(logic [7:0] idx);
    logic [8:0] p;
    p = {1'b0, oldest} + {1'b0, idx};
    if (p >= cap) p = p - cap;
    return p[7:0];
  endfunction

  function out_item_t ring_step(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.kind)
      KIND_APPEND: begin
        if ({1'b0, newest} + 9'd1 < cap) newest = newest + 8'd1;
        else newest = 8'd0;
        slots[newest] = it.value;
        if (count < cap) begin
          count = count + 9'd1;
          r.ok  = 1'b1;
        end else begin
          find_oldest();
        end
      end
      KIND_READ: begin
        if ({1'b0, it.index} < cap) begin
          r.read_data = slots[slot_of(it.index)];
          r.ok        = 1'b1;
        end
      end
      KIND_WRITE: begin
        if ({1'b0, it.index} < cap) begin
          slots[slot_of(it.index)] = it.value;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (count != 9'd0) begin
          count = count - 9'd1;
          r.ok  = 1'b1;
          find_oldest();
        end
      end
      KIND_CLEAR: begin
        empty_ring();
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.fill_count = count;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (slots[i]) slots[i] = 8'd0;
      cap = 9'd256;
      empty_ring();
      pending_results.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          if (bad < 10) $display("%0t: result beat with none expected: %p", $realtime, out_item);
          bad++;
        end else begin
          want = pending_results.pop_front();
          if (out_item !== want) begin
            if (bad < 10) begin
              $display("%0t: expected data %h ok %b fill %0d, got data %h ok %b fill %0d",
                       $realtime, want.read_data, want.ok, want.fill_count,
                       out_item.read_data, out_item.ok, out_item.fill_count);
            end
            bad++;
          end
        end
      end
      if (cfg_wr_en === 1'b1) begin
        cap = clamp_capacity(cfg_wr_data);
        empty_ring();
      end
      if (start === 1'b1 && busy === 1'b0) pending_results.push_back(ring_step(in_item));
    end
    failures <= bad;
    waiting  <= pending_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Ring buffer testbench
// Drives directed and random operations into the overwriting ring byte
// buffer across a range of capacities, with random gaps between beats, and
// gives the verdict from the checker's failure and open prediction counts.
// ----------------------------------------------------------------------------
module tb
  import orbb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_wr_en = 1'b0;
  logic [8:0] cfg_wr_data = '0;
  int         failures;
  int         waiting;

  always #5 clk = ~clk;

  overwriting_ring_byte_buffer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  orbb_checker ring_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .failures    (failures),
    .waiting     (waiting)
  );

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic in_item_t beat_of(logic [2:0] k, logic [7:0] i, logic [7:0] v);
    in_item_t it;
    it.kind  = k;
    it.index = i;
    it.value = v;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [2:0] pick_kind(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 65) return KIND_APPEND;
      if (r < 80) return KIND_READ;
      if (r < 92) return KIND_WRITE;
      if (r < 97) return KIND_REMOVE;
    end else begin
      if (r < 35) return KIND_APPEND;
      if (r < 60) return KIND_READ;
      if (r < 80) return KIND_WRITE;
      if (r < 92) return KIND_REMOVE;
      if (r < 96) return KIND_CLEAR;
    end
    return KIND_CLEAR + 3'($urandom_range(1, 3));
  endfunction

  task automatic issue(in_item_t it, int gap);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    int n;
    start <= 1'b0;
    repeat (2) @(posedge clk);
    for (n = 0; waiting != 0 && n < 5000; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [8:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(logic [8:0] cap_word, int n_items, bit filling);
    int       eff;
    bit       steady;
    in_item_t it;
    set_capacity(cap_word);
    eff = (cap_word == 9'd0) ? 1 : ((cap_word > 9'd256) ? 256 : int'(cap_word));
    steady = ($urandom_range(0, 3) == 0);
    repeat (n_items) begin
      it.kind  = pick_kind(filling);
      it.index = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, eff - 1)) : 8'($urandom);
      it.value = 8'($urandom);
      issue(it, steady ? 0 : pick_gap());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    issue(beat_of(KIND_READ, 8'd0, 8'd0), 0);
    issue(beat_of(KIND_READ, 8'd255, 8'd0), pick_gap());
    issue(beat_of(KIND_REMOVE, 8'd0, 8'd0), 0);
    issue(beat_of(KIND_APPEND, 8'd0, 8'h00), 0);
    issue(beat_of(KIND_APPEND, 8'd0, 8'hff), pick_gap());
    issue(beat_of(KIND_APPEND, 8'd0, 8'ha5), 0);
    issue(beat_of(KIND_READ, 8'd1, 8'd0), 0);
    issue(beat_of(KIND_READ, 8'd200, 8'd0), pick_gap());
    issue(beat_of(KIND_WRITE, 8'd255, 8'hff), 0);
    issue(beat_of(KIND_READ, 8'd255, 8'd0), 0);
    issue(beat_of(KIND_WRITE, 8'd1, 8'h00), 0);
    issue(beat_of(KIND_REMOVE, 8'd0, 8'd0), 0);
    issue(beat_of(KIND_READ, 8'd0, 8'd0), pick_gap());
    issue(beat_of(KIND_CLEAR + 3'd1, 8'hff, 8'hff), 0);
    issue(beat_of(KIND_CLEAR + 3'd2, 8'hff, 8'hff), 0);
    issue(beat_of(KIND_CLEAR + 3'd3, 8'hff, 8'hff), 0);
    issue(beat_of(KIND_CLEAR, 8'd0, 8'd0), 0);

    set_capacity(9'd3);
    repeat (4) issue(beat_of(KIND_APPEND, 8'd0, 8'($urandom)), 0);
    issue(beat_of(KIND_READ, 8'd3, 8'd0), 0);
    issue(beat_of(KIND_WRITE, 8'd3, 8'h5a), 0);
    issue(beat_of(KIND_READ, 8'd0, 8'd0), 0);
    issue(beat_of(KIND_READ, 8'd2, 8'd0), 0);
    repeat (4) issue(beat_of(KIND_REMOVE, 8'd0, 8'd0), pick_gap());

    run_phase(9'd511, 520, 1'b1);
    run_phase(9'd0, 80, 1'b0);
    run_phase(9'd2, 80, 1'b0);
    run_phase(9'd5, 80, 1'b0);
    run_phase(9'd16, 80, 1'b0);
    run_phase(9'd256, 150, 1'b0);
    run_phase(9'd1, 80, 1'b0);
    run_phase(9'd40, 80, 1'b0);
    run_phase(9'd255, 150, 1'b1);
    run_phase(9'($urandom_range(0, 511)), 80, 1'b0);

    drain();
    if (failures == 0 && waiting == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/orbb_pkg.sv
rtl/core/orbb_ctrl.sv
rtl/core/orbb_dpath.sv
rtl/core/overwriting_ring_byte_buffer_unit.sv
verif/orbb_checker.sv
verif/tb.sv
